// ===== hw/rtl/itok_pkg.sv =====
// Shared types, codes and constants of the IRC line tokenizer.
package itok_pkg;

    // Field widths.
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int MAXLEN_W = 12;
    localparam int LEN_W    = 13;

    // Reset value of the line length limit and the saturation point of the counter.
    localparam logic [MAXLEN_W-1:0] MAX_LEN_RESET = 12'd512;
    localparam logic [LEN_W-1:0]    LEN_SAT       = 13'd8191;

    // Special bytes.
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;

    // PRIVMSG matcher: index of a full match and the broken marker.
    localparam logic [3:0] MATCH_FULL   = 4'd7;
    localparam logic [3:0] MATCH_BROKEN = 4'd8;

    // Token kinds.
    localparam logic [KIND_W-1:0] KIND_PREFIX   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COMMAND  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MIDDLE   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TRAILING = 2'd3;

    // Line status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_COMMAND = 2'd2;

    // Parse phase of the current line.
    typedef enum logic [2:0] {
        PH_LINE_START,
        PH_PREFIX,
        PH_SEP_CMD,
        PH_COMMAND,
        PH_SEP_PARAM,
        PH_MIDDLE,
        PH_TRAILING
    } t_phase;

    // One result item as it travels from the parser to the result queue.
    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic [KIND_W-1:0]   token_kind;
        logic                token_start;
        logic                line_end;
        logic [STATUS_W-1:0] line_status;
        logic                last;
    } t_result;

    // Letters of the word PRIVMSG, by position.
    function automatic logic [BYTE_W-1:0] privmsg_char(input logic [2:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            3'd0:    c = 8'h50; // P
            3'd1:    c = 8'h52; // R
            3'd2:    c = 8'h49; // I
            3'd3:    c = 8'h56; // V
            3'd4:    c = 8'h4D; // M
            3'd5:    c = 8'h53; // S
            3'd6:    c = 8'h47; // G
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Separator whitespace: space, tab, vertical tab, form feed.
    function automatic logic is_sep(input logic [BYTE_W-1:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF);
    endfunction

endpackage

// ===== hw/rtl/itok_parser.sv =====
// Per-byte parse state and classification logic of the IRC line tokenizer.
module itok_parser
    import itok_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [BYTE_W-1:0]   i_byte,
    input  logic [MAXLEN_W-1:0] i_max_len,
    output t_result             o_res0,
    output t_result             o_res1,
    output logic [1:0]          o_count
);

    t_phase           r_phase, n_phase;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_acr, n_acr;
    logic             r_cmd_seen, n_cmd_seen;
    logic [3:0]       r_idx, n_idx;
    logic             r_matched, n_matched;
    logic             r_trail_first, n_trail_first;
    logic             r_pend, n_pend;

    // Parse state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_LINE_START;
            r_len         <= '0;
            r_acr         <= 1'b0;
            r_cmd_seen    <= 1'b0;
            r_idx         <= '0;
            r_matched     <= 1'b0;
            r_trail_first <= 1'b0;
            r_pend        <= 1'b1;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_len         <= n_len;
            r_acr         <= n_acr;
            r_cmd_seen    <= n_cmd_seen;
            r_idx         <= n_idx;
            r_matched     <= n_matched;
            r_trail_first <= n_trail_first;
            r_pend        <= n_pend;
        end
    end

    // Classification of the presented byte and the next parse state.
    always_comb begin
        logic             ws;
        logic [3:0]       step_idx;
        logic             pend;
        t_result          r0;
        t_result          r1;
        logic [1:0]       cnt;

        ws       = is_sep(i_byte);
        r0       = '0;
        r1       = '0;
        cnt      = 2'd0;
        pend     = r_pend;

        // Advance of the PRIVMSG matcher for a command byte.
        if ((r_idx < MATCH_FULL) && (i_byte == privmsg_char(r_idx[2:0]))) begin
            step_idx = r_idx + 4'd1;
        end else begin
            step_idx = MATCH_BROKEN;
        end

        n_phase       = r_phase;
        n_len         = r_len;
        n_acr         = r_acr;
        n_cmd_seen    = r_cmd_seen;
        n_idx         = r_idx;
        n_matched     = r_matched;
        n_trail_first = r_trail_first;
        n_pend        = r_pend;

        if ((i_byte == CH_LF) && r_acr) begin
            // The LF of a CR-LF pair is swallowed.
            n_acr = 1'b0;
        end else if ((i_byte == CH_CR) || (i_byte == CH_LF)) begin
            // Line end: report status and start a fresh line.
            r0.line_end = 1'b1;
            if (r_len > {1'b0, i_max_len}) begin
                r0.line_status = ST_TOO_LONG;
            end else if (!r_cmd_seen) begin
                r0.line_status = ST_NO_COMMAND;
            end else begin
                r0.line_status = ST_OK;
            end
            cnt           = 2'd1;
            n_phase       = PH_LINE_START;
            n_len         = '0;
            n_cmd_seen    = 1'b0;
            n_idx         = '0;
            n_matched     = 1'b0;
            n_trail_first = 1'b0;
            n_pend        = 1'b1;
            n_acr         = (i_byte == CH_CR);
        end else begin
            n_acr = 1'b0;
            if (r_len != LEN_SAT) begin
                n_len = r_len + 13'd1;
            end
            case (r_phase)
                PH_LINE_START: begin
                    if (i_byte == CH_COLON) begin
                        n_phase = PH_PREFIX;
                        n_pend  = 1'b1;
                    end else if (ws) begin
                        n_phase = PH_SEP_CMD;
                    end else begin
                        n_cmd_seen     = 1'b1;
                        n_idx          = step_idx;
                        r0.out_byte    = i_byte;
                        r0.token_kind  = KIND_COMMAND;
                        r0.token_start = 1'b1;
                        cnt            = 2'd1;
                        n_phase        = PH_COMMAND;
                    end
                end
                PH_PREFIX: begin
                    if (ws) begin
                        n_phase = PH_SEP_CMD;
                    end else begin
                        r0.out_byte    = i_byte;
                        r0.token_kind  = KIND_PREFIX;
                        r0.token_start = r_pend;
                        cnt            = 2'd1;
                        n_pend         = 1'b0;
                    end
                end
                PH_SEP_CMD: begin
                    if (!ws) begin
                        n_cmd_seen     = 1'b1;
                        n_idx          = step_idx;
                        r0.out_byte    = i_byte;
                        r0.token_kind  = KIND_COMMAND;
                        r0.token_start = 1'b1;
                        cnt            = 2'd1;
                        n_phase        = PH_COMMAND;
                    end
                end
                PH_COMMAND: begin
                    if (ws) begin
                        n_matched = (r_idx == MATCH_FULL);
                        n_phase   = PH_SEP_PARAM;
                    end else begin
                        n_idx         = step_idx;
                        r0.out_byte   = i_byte;
                        r0.token_kind = KIND_COMMAND;
                        cnt           = 2'd1;
                    end
                end
                PH_SEP_PARAM: begin
                    if (!ws) begin
                        if (i_byte == CH_COLON) begin
                            n_phase       = PH_TRAILING;
                            n_pend        = 1'b1;
                            n_trail_first = 1'b1;
                        end else begin
                            r0.out_byte    = i_byte;
                            r0.token_kind  = KIND_MIDDLE;
                            r0.token_start = 1'b1;
                            cnt            = 2'd1;
                            n_phase        = PH_MIDDLE;
                        end
                    end
                end
                PH_MIDDLE: begin
                    if (ws) begin
                        n_phase = PH_SEP_PARAM;
                    end else begin
                        r0.out_byte   = i_byte;
                        r0.token_kind = KIND_MIDDLE;
                        cnt           = 2'd1;
                    end
                end
                PH_TRAILING: begin
                    // Non-PRIVMSG commands get one extra space before the first separator.
                    if (r_trail_first && ws) begin
                        n_trail_first = 1'b0;
                        if (!r_matched) begin
                            r0.out_byte    = CH_SPACE;
                            r0.token_kind  = KIND_TRAILING;
                            r0.token_start = pend;
                            pend           = 1'b0;
                            cnt            = 2'd1;
                        end
                    end
                    if (cnt == 2'd1) begin
                        r1.out_byte    = i_byte;
                        r1.token_kind  = KIND_TRAILING;
                        r1.token_start = pend;
                        cnt            = 2'd2;
                    end else begin
                        r0.out_byte    = i_byte;
                        r0.token_kind  = KIND_TRAILING;
                        r0.token_start = pend;
                        cnt            = 2'd1;
                    end
                    n_pend = 1'b0;
                end
                default: begin
                    n_phase = PH_LINE_START;
                end
            endcase
        end

        // Mark the final result of this byte.
        if (cnt == 2'd2) begin
            r1.last = 1'b1;
        end else if (cnt == 2'd1) begin
            r0.last = 1'b1;
        end

        o_res0  = r0;
        o_res1  = r1;
        o_count = i_fire ? cnt : 2'd0;
    end

endmodule

// ===== hw/rtl/itok_result_queue.sv =====
// Four-entry result queue that takes up to two results per cycle and gives one.
module itok_result_queue
    import itok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_result    i_res0,
    input  t_result    i_res1,
    input  logic [1:0] i_push,
    output logic       o_room,
    output logic       o_valid,
    input  logic       i_pop,
    output t_result    o_res
);

    t_result    r_mem [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_count;
    logic       pop;

    assign pop     = i_pop && (r_count != 3'd0);
    assign o_valid = (r_count != 3'd0);
    assign o_room  = (r_count < 3'd3);
    assign o_res   = r_mem[r_rd];

    // Storage writes: first result at the write pointer, second one after it.
    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push == 2'd2) begin
            r_mem[r_wr + 2'd1] <= i_res1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + i_push;
            r_rd    <= r_rd + {1'b0, pop};
            r_count <= r_count + {1'b0, i_push} - {2'b00, pop};
        end
    end

endmodule

// ===== hw/rtl/irc_line_tokenizer_core.sv =====
// Top level of the IRC line tokenizer: ports, length limit register and glue.
//
// Bytes of an IRC stream enter one per cycle while the input is ready; CR, LF
// or CR-LF ends a line and produces a status result. A byte is parsed at the
// edge where its request is accepted. Most bytes cause zero or one result, and
// then one byte per cycle flows through while results are taken. The first
// separator of a trailing parameter of a non-PRIVMSG command causes two
// results, which leave the queue one at a time. Results wait in a four-entry
// queue, and the input is ready while that queue holds at most two results, so
// a stalled consumer stops the input once three results wait. The length limit
// is written through the configuration port and takes effect on the next byte.
module irc_line_tokenizer_core
    import itok_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration: line length limit.
    input  logic                i_cfg_we,
    input  logic [MAXLEN_W-1:0] i_cfg_data,
    // Input byte channel.
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [BYTE_W-1:0]   i_data_byte,
    // Result channel.
    output logic                o_valid,
    input  logic                i_ready,
    output logic [BYTE_W-1:0]   o_out_byte,
    output logic [KIND_W-1:0]   o_token_kind,
    output logic                o_token_start,
    output logic                o_line_end,
    output logic [STATUS_W-1:0] o_line_status,
    output logic                o_last
);

    logic [MAXLEN_W-1:0] r_max_len;
    logic                fire;
    logic                room;
    t_result             res0, res1, res_out;
    logic [1:0]          push;

    // Line length limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_data;
        end
    end

    assign o_ready = room;
    assign fire    = i_valid && room;

    // Byte classification and parse state.
    itok_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_byte    (i_data_byte),
        .i_max_len (r_max_len),
        .o_res0    (res0),
        .o_res1    (res1),
        .o_count   (push)
    );

    // Result queue between the parser and the consumer.
    itok_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res0  (res0),
        .i_res1  (res1),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_pop   (i_ready),
        .o_res   (res_out)
    );

    assign o_out_byte    = res_out.out_byte;
    assign o_token_kind  = res_out.token_kind;
    assign o_token_start = res_out.token_start;
    assign o_line_end    = res_out.line_end;
    assign o_line_status = res_out.line_status;
    assign o_last        = res_out.last;

endmodule

// ===== hw/rtl/itok_checker.sv =====
// Port-level checker of the IRC line tokenizer and its bind to the top level.
module itok_checker
    import itok_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_ready,
    input logic [BYTE_W-1:0]   o_out_byte,
    input logic [KIND_W-1:0]   o_token_kind,
    input logic                o_token_start,
    input logic                o_line_end,
    input logic [STATUS_W-1:0] o_line_status,
    input logic                o_last
);

    // A stalled result request keeps its valid, byte, line-end flag and last flag.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_line_end)
            && $stable(o_last))
        else $error("stalled result changed");

    // A line-end result is always the final result of its byte.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_line_end |-> o_last)
        else $error("line end without last");

    // A line-end result carries no token content.
    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_line_end |-> (o_out_byte == 8'h00) && (o_token_kind == KIND_PREFIX)
            && !o_token_start)
        else $error("line end with token content");

    // Token results carry an ok status.
    a_tok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_line_end |-> (o_line_status == ST_OK))
        else $error("status on a token result");

    // Reset empties the result queue.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind irc_line_tokenizer_core itok_checker u_itok_checker (.*);
